@@ src/round_robin_schedule_sim_assert.svh @@
// Assertion macros used by the round-robin scheduler datapath.
`ifndef ROUND_ROBIN_SCHEDULE_SIM_ASSERT_SVH
`define ROUND_ROBIN_SCHEDULE_SIM_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rrs_pkg.sv @@
// Shared widths, reset values and controller/datapath interface types.
package rrs_pkg;

  localparam int unsigned ARR_W        = 16;
  localparam int unsigned BUR_W        = 16;
  localparam int unsigned TQ_W         = 8;
  localparam int unsigned PNUM_W       = 4;
  localparam int unsigned RES_W        = 20;
  localparam int unsigned MAX_PROC_DEF = 16;

  localparam logic [TQ_W-1:0] TQ_RESET = 8'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store an accepted process
    logic admit;      // push next arrival into the ready ring
    logic set_time;   // jump clock to next arrival
    logic pop;        // take head of ready ring
    logic take_p;     // latch popped process index
    logic fetch;      // latch remaining service of popped process
    logic tick;       // run one tick of service
    logic end_turn;   // finish or requeue the running process
    logic out_phase;  // steer arrival read port to result index
    logic out_tat;    // compute turnaround
    logic out_wt;     // compute waiting, load result registers
    logic out_next;   // advance result index
    logic clear;      // drop the finished set
  } rrs_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic can_admit;
    logic ring_empty;
    logic all_admitted;
    logic turn_go;
    logic last_out;
  } rrs_stat_t;

endpackage

@@ src/rrs_ctrl.sv @@
// Scheduler controller: load, simulation and result sequencing state machine.
module rrs_ctrl import rrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      last_process_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rrs_stat_t stat_i,
  output rrs_cmd_t  cmd_o
);

  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_PRIME     = 4'd1;
  localparam logic [3:0] S_SELECT    = 4'd2;
  localparam logic [3:0] S_ADMIT_SEL = 4'd3;
  localparam logic [3:0] S_POP       = 4'd4;
  localparam logic [3:0] S_POP_WAIT  = 4'd5;
  localparam logic [3:0] S_FETCH     = 4'd6;
  localparam logic [3:0] S_RUN       = 4'd7;
  localparam logic [3:0] S_ADMIT_RUN = 4'd8;
  localparam logic [3:0] S_OUT_RD    = 4'd9;
  localparam logic [3:0] S_OUT_TAT   = 4'd10;
  localparam logic [3:0] S_OUT_WT    = 4'd11;
  localparam logic [3:0] S_OUT_SEND  = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = (state_q == S_OUT_SEND);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_process_i) state_d = S_PRIME;
        end
      end
      S_PRIME: begin
        // arrival of process 0 settles in the read register
        state_d = S_SELECT;
      end
      S_SELECT: begin
        if (!stat_i.ring_empty) begin
          cmd_o.pop = 1'b1;
          state_d   = S_POP;
        end else if (stat_i.all_admitted) begin
          cmd_o.out_phase = 1'b1;
          state_d         = S_OUT_RD;
        end else begin
          cmd_o.set_time = 1'b1;
          state_d        = S_ADMIT_SEL;
        end
      end
      S_ADMIT_SEL: begin
        if (stat_i.can_admit) cmd_o.admit = 1'b1;
        else                  state_d     = S_SELECT;
      end
      S_POP: begin
        // latch the head entry while it sits in the ring read register
        cmd_o.take_p = 1'b1;
        state_d      = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        // remaining service of the popped process settles in the read register
        state_d = S_FETCH;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_RUN;
      end
      S_RUN: begin
        if (stat_i.turn_go) begin
          cmd_o.tick = 1'b1;
          state_d    = S_ADMIT_RUN;
        end else begin
          cmd_o.end_turn = 1'b1;
          state_d        = S_SELECT;
        end
      end
      S_ADMIT_RUN: begin
        if (stat_i.can_admit) cmd_o.admit = 1'b1;
        else                  state_d     = S_RUN;
      end
      S_OUT_RD: begin
        cmd_o.out_phase = 1'b1;
        state_d         = S_OUT_TAT;
      end
      S_OUT_TAT: begin
        cmd_o.out_tat = 1'b1;
        state_d       = S_OUT_WT;
      end
      S_OUT_WT: begin
        cmd_o.out_wt = 1'b1;
        state_d      = S_OUT_SEND;
      end
      S_OUT_SEND: begin
        if (out_ready_i) begin
          if (stat_i.last_out) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            cmd_o.out_next = 1'b1;
            state_d        = S_OUT_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/rrs_dp.sv @@
// Scheduler datapath: process stores, ready ring, clock and result arithmetic.
`include "round_robin_schedule_sim_assert.svh"

module rrs_dp import rrs_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = MAX_PROC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TQ_W-1:0]   cfg_wdata_i,
  input  logic [ARR_W-1:0]  arrival_time_i,
  input  logic [BUR_W-1:0]  burst_time_i,
  input  rrs_cmd_t          cmd_i,
  output rrs_stat_t         stat_o,
  output logic [PNUM_W-1:0] process_number_o,
  output logic [RES_W-1:0]  turnaround_time_o,
  output logic [RES_W-1:0]  waiting_time_o,
  output logic              last_result_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned TIME_W = ARR_W + CNT_W;
  localparam int unsigned SAT_W  = (TIME_W > RES_W) ? TIME_W : RES_W;

  localparam logic [CNT_W-1:0] MaxCnt  = CNT_W'(MAX_PROCESSES);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_PROCESSES - 1);
  localparam logic [SAT_W-1:0] ResMax  = SAT_W'({RES_W{1'b1}});

  // stores
  logic [ARR_W-1:0]  arr_mem  [MAX_PROCESSES];
  logic [BUR_W-1:0]  bur_mem  [MAX_PROCESSES];
  logic [BUR_W-1:0]  rem_mem  [MAX_PROCESSES];
  logic [TIME_W-1:0] cmp_mem  [MAX_PROCESSES];
  logic [IDX_W-1:0]  ring_mem [MAX_PROCESSES];

  logic [ARR_W-1:0]  arr_rd_q;
  logic [BUR_W-1:0]  bur_rd_q;
  logic [BUR_W-1:0]  rem_rd_q;
  logic [TIME_W-1:0] cmp_rd_q;
  logic [IDX_W-1:0]  ring_rd_q;

  // control registers
  logic [TQ_W-1:0]   tq_q;
  logic [CNT_W-1:0]  loaded_q, loaded_d;
  logic [CNT_W-1:0]  next_adm_q, next_adm_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TQ_W-1:0]   ran_q, ran_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;

  // payload registers
  logic [IDX_W-1:0]  cur_p_q;
  logic [BUR_W-1:0]  cur_rem_q;
  logic [TIME_W-1:0] tat_q;
  logic [PNUM_W-1:0] pnum_q;
  logic [RES_W-1:0]  tat_out_q;
  logic [RES_W-1:0]  wt_out_q;
  logic              last_out_q;

  logic              room;
  logic              requeue;
  logic              push;
  logic [IDX_W-1:0]  push_data;
  logic [IDX_W-1:0]  arr_raddr;
  logic [TQ_W-1:0]   q_eff;
  logic [SAT_W-1:0]  tat_ext;
  logic [SAT_W-1:0]  wt_ext;
  logic [IDX_W+PNUM_W-1:0] pnum_wide;

  assign room      = (loaded_q < MaxCnt);
  assign requeue   = cmd_i.end_turn && (cur_rem_q != '0);
  assign push      = cmd_i.admit || requeue;
  assign push_data = cmd_i.admit ? next_adm_q[IDX_W-1:0] : cur_p_q;
  assign q_eff     = (tq_q == '0) ? TQ_W'(1) : tq_q;
  assign arr_raddr = cmd_i.out_phase ? out_idx_q : next_adm_d[IDX_W-1:0];

  // status to the controller
  assign stat_o.can_admit    = (next_adm_q < loaded_q) && (TIME_W'(arr_rd_q) <= time_q);
  assign stat_o.ring_empty   = (count_q == '0);
  assign stat_o.all_admitted = (next_adm_q >= loaded_q);
  assign stat_o.turn_go      = (cur_rem_q != '0) && (ran_q < q_eff);
  assign stat_o.last_out     = ((CNT_W'(out_idx_q) + CNT_W'(1)) == loaded_q);

  // next values of the control registers
  always_comb begin
    loaded_d   = loaded_q;
    next_adm_d = next_adm_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    time_d     = time_q;
    ran_d      = ran_q;
    out_idx_d  = out_idx_q;
    if (cmd_i.load && room) loaded_d = loaded_q + CNT_W'(1);
    if (cmd_i.admit) next_adm_d = next_adm_q + CNT_W'(1);
    if (push) tail_d = (tail_q == LastIdx) ? '0 : tail_q + IDX_W'(1);
    if (cmd_i.pop) head_d = (head_q == LastIdx) ? '0 : head_q + IDX_W'(1);
    if (push && !cmd_i.pop) count_d = count_q + CNT_W'(1);
    if (cmd_i.pop && !push) count_d = count_q - CNT_W'(1);
    if (cmd_i.set_time) time_d = TIME_W'(arr_rd_q);
    if (cmd_i.tick)     time_d = time_q + TIME_W'(1);
    if (cmd_i.fetch) ran_d = '0;
    if (cmd_i.tick)  ran_d = ran_q + TQ_W'(1);
    if (cmd_i.out_next) out_idx_d = out_idx_q + IDX_W'(1);
    if (cmd_i.clear) begin
      loaded_d   = '0;
      next_adm_d = '0;
      head_d     = '0;
      tail_d     = '0;
      count_d    = '0;
      time_d     = '0;
      out_idx_d  = '0;
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tq_q       <= TQ_RESET;
      loaded_q   <= '0;
      next_adm_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      time_q     <= '0;
      ran_q      <= '0;
      out_idx_q  <= '0;
    end else begin
      if (cfg_we_i) tq_q <= cfg_wdata_i;
      loaded_q   <= loaded_d;
      next_adm_q <= next_adm_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      time_q     <= time_d;
      ran_q      <= ran_d;
      out_idx_q  <= out_idx_d;
    end
  end

  // write and read the process stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      arr_mem[loaded_q[IDX_W-1:0]] <= arrival_time_i;
      bur_mem[loaded_q[IDX_W-1:0]] <= burst_time_i;
    end
    if (cmd_i.load && room) begin
      rem_mem[loaded_q[IDX_W-1:0]] <= burst_time_i;
    end else if (requeue) begin
      rem_mem[cur_p_q] <= cur_rem_q;
    end
    if (cmd_i.end_turn && !requeue) cmp_mem[cur_p_q] <= time_q;
    if (push) ring_mem[tail_q] <= push_data;
    arr_rd_q  <= arr_mem[arr_raddr];
    bur_rd_q  <= bur_mem[out_idx_q];
    cmp_rd_q  <= cmp_mem[out_idx_q];
    ring_rd_q <= ring_mem[head_q];
    rem_rd_q  <= rem_mem[cur_p_q];
  end

  // track the running process
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_p) cur_p_q <= ring_rd_q;
    if (cmd_i.fetch)  cur_rem_q <= rem_rd_q;
    else if (cmd_i.tick) cur_rem_q <= cur_rem_q - BUR_W'(1);
  end

  // form results, saturating to the result width
  assign tat_ext   = SAT_W'(tat_q);
  assign wt_ext    = SAT_W'(tat_q - TIME_W'(bur_rd_q));
  assign pnum_wide = {PNUM_W'(0), out_idx_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_tat) tat_q <= cmp_rd_q - TIME_W'(arr_rd_q);
    if (cmd_i.out_wt) begin
      pnum_q     <= pnum_wide[PNUM_W-1:0];
      tat_out_q  <= (tat_ext > ResMax) ? {RES_W{1'b1}} : tat_ext[RES_W-1:0];
      wt_out_q   <= (wt_ext > ResMax) ? {RES_W{1'b1}} : wt_ext[RES_W-1:0];
      last_out_q <= stat_o.last_out;
    end
  end

  assign process_number_o  = pnum_q;
  assign turnaround_time_o = tat_out_q;
  assign waiting_time_o    = wt_out_q;
  assign last_result_o     = last_out_q;

  // checks
  `RRS_ASSERT_IMP(a_push_room, push, count_q < MaxCnt, "push into full ready ring")
  `RRS_ASSERT_IMP(a_pop_nonempty, cmd_i.pop, count_q != '0, "pop from empty ready ring")
  `RRS_ASSERT_IMP(a_tick_work, cmd_i.tick, cur_rem_q != '0, "tick with no service left")
  `RRS_ASSERT_IMP(a_jump_fwd, cmd_i.set_time, TIME_W'(arr_rd_q) >= time_q, "clock moved back")
  `RRS_ASSERT_NXT(a_clear_idle, cmd_i.clear, (count_q == '0) && (loaded_q == '0), "set not cleared")

endmodule

@@ src/round_robin_schedule_sim.sv @@
// Loading takes one process per cycle, stalled while a set is simulated or reported.
// Simulation: a prime step; per service tick a run step and an admit step that takes
// each arrived process; per turn ring pop, store reads and turn end; per idle clock
// jump a select and an admit step, as the single-port stores and controller set them.
// Results: read, turnaround, waiting, send, held by output stall. Reset (async, low)
// clears all control state, sets the quantum to 1; stores hold garbage until loaded.
module round_robin_schedule_sim import rrs_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = MAX_PROC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TQ_W-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ARR_W-1:0]  arrival_time_i,
  input  logic [BUR_W-1:0]  burst_time_i,
  input  logic              last_process_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PNUM_W-1:0] process_number_o,
  output logic [RES_W-1:0]  turnaround_time_o,
  output logic [RES_W-1:0]  waiting_time_o,
  output logic              last_result_o
);

  rrs_cmd_t  cmd;
  rrs_stat_t stat;

  // sequence the phases
  rrs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .last_process_i (last_process_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // store processes, run the queue, form results
  rrs_dp #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .arrival_time_i    (arrival_time_i),
    .burst_time_i      (burst_time_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .process_number_o  (process_number_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .last_result_o     (last_result_o)
  );

endmodule
